@@ hdl/icf_pkg.sv @@
// Shared types, constants and saturating helpers for the image-charge
// conformal factor block. No dependencies.
package icf_pkg;

  localparam int WORD_BITS = 48;
  localparam int FRAC_BITS = 24;
  localparam int TOL_BITS  = 40;
  localparam int RAD_BITS  = 47;
  localparam int MT_BITS   = 6;
  localparam int PSI_BITS  = 47;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
  localparam int CNT_BITS  = $clog2(NUM_BITS + 1);
  localparam int REM_BITS  = WORD_BITS + 4;
  localparam int CFG_IDX_BITS = 3;

  localparam logic signed [WORD_BITS-1:0] MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] MINV = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [WORD_BITS-1:0] ONE_Q = WORD_BITS'(1) << FRAC_BITS;
  localparam logic signed [WORD_BITS-1:0] HALF_Q = WORD_BITS'(1) << (FRAC_BITS - 1);

  localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEP    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOL    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAXT   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIDE   = 3'd4;

  localparam logic [1:0] ST_CONV = 2'd0;
  localparam logic [1:0] ST_CAP  = 2'd1;
  localparam logic [1:0] ST_DZ   = 2'd2;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] pos_x;
    logic signed [WORD_BITS-1:0] pos_y;
    logic signed [WORD_BITS-1:0] pos_z;
  } icf_in_t;

  typedef struct packed {
    logic [PSI_BITS-1:0] psi_value;
    logic [1:0]          status;
  } icf_out_t;

  typedef struct packed {
    logic [RAD_BITS-1:0]         hole_radius;
    logic signed [WORD_BITS-1:0] hole_separation;
    logic [TOL_BITS-1:0]         tolerance;
    logic [MT_BITS-1:0]          max_terms;
    logic                        image_side;
  } icf_cfg_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DX, OP_SQX, OP_SQY, OP_SQZ, OP_SQRT, OP_TERM,
    OP_TOL, OP_SUMS, OP_DIVRS, OP_MULCQ, OP_MULRR, OP_DIVRRS, OP_NEWD, OP_OUT
  } icf_op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DX, S_SQX, S_SQY, S_SQZ, S_SQRT, S_TERM, S_TOL,
    S_SUMS, S_DIVRS, S_MULCQ, S_MULRR, S_DIVRRS, S_NEWD, S_OUT
  } icf_state_t;

  typedef struct packed {
    icf_op_t op;
    logic    capped;
  } icf_cmd_t;

  typedef struct packed {
    logic done;
    logic conv;
  } icf_sts_t;

  function automatic logic signed [WORD_BITS-1:0] add_sat(
      input logic signed [WORD_BITS-1:0] a, input logic signed [WORD_BITS-1:0] b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? MINV : MAXV;
    return s[WORD_BITS-1:0];
  endfunction

  function automatic logic signed [WORD_BITS-1:0] sub_sat(
      input logic signed [WORD_BITS-1:0] a, input logic signed [WORD_BITS-1:0] b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? MINV : MAXV;
    return s[WORD_BITS-1:0];
  endfunction

  function automatic logic [WORD_BITS-1:0] mag(input logic signed [WORD_BITS-1:0] a);
    return a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
  endfunction

  // Signed result from a wide magnitude, saturating to the word range.
  function automatic logic signed [WORD_BITS-1:0] sat_mag(
      input logic [NUM_BITS-1:0] v, input logic neg);
    if (|v[NUM_BITS-1:WORD_BITS-1]) return neg ? MINV : MAXV;
    return neg ? -$signed(v[WORD_BITS-1:0]) : $signed(v[WORD_BITS-1:0]);
  endfunction

endpackage

@@ hdl/icf_ctrl.sv @@
// Sequencer for the image series: issues one datapath operation at a time
// and owns the handshake state. Depends on icf_pkg.
module icf_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  input  logic [icf_pkg::MT_BITS-1:0] max_terms,
  input  icf_pkg::icf_sts_t       sts,
  output icf_pkg::icf_cmd_t       cmd
);
  import icf_pkg::*;

  icf_state_t state_r, state_nxt;
  logic wait_r, wait_nxt;
  logic [MT_BITS-1:0] n_r, n_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    icf_state_t adv;
    icf_op_t    op;
    adv           = state_r;
    op            = OP_NONE;
    state_nxt     = state_r;
    wait_nxt      = wait_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.capped    = (n_r == max_terms);

    unique case (state_r)
      S_IDLE:   begin op = OP_LOAD;   adv = S_DX;     end
      S_DX:     begin op = OP_DX;     adv = S_SQX;    end
      S_SQX:    begin op = OP_SQX;    adv = S_SQY;    end
      S_SQY:    begin op = OP_SQY;    adv = S_SQZ;    end
      S_SQZ:    begin op = OP_SQZ;    adv = S_SQRT;   end
      S_SQRT:   begin op = OP_SQRT;   adv = S_TERM;   end
      S_TERM:   begin op = OP_TERM;   adv = S_TOL;    end
      S_TOL: begin
        op  = OP_TOL;
        adv = (sts.conv || n_r == max_terms) ? S_OUT : S_SUMS;
      end
      S_SUMS:   begin op = OP_SUMS;   adv = S_DIVRS;  end
      S_DIVRS:  begin op = OP_DIVRS;  adv = S_MULCQ;  end
      S_MULCQ:  begin op = OP_MULCQ;  adv = S_MULRR;  end
      S_MULRR:  begin op = OP_MULRR;  adv = S_DIVRRS; end
      S_DIVRRS: begin op = OP_DIVRRS; adv = S_NEWD;   end
      S_NEWD:   begin op = OP_NEWD;   adv = S_DX;     end
      S_OUT:    begin op = OP_OUT;    adv = S_IDLE;   end
      default:  begin op = OP_NONE;   adv = S_IDLE;   end
    endcase

    cmd.op = OP_NONE;
    priority if (state_r == S_IDLE) begin
      if (in_valid) begin
        cmd.op    = op;
        n_nxt     = '0;
        state_nxt = adv;
        wait_nxt  = 1'b0;
      end
    end else if (state_r == S_OUT) begin
      // hold the result until the previous beat has left
      if (!out_valid_r || !out_stall) begin
        cmd.op        = op;
        out_valid_nxt = 1'b1;
        state_nxt     = adv;
      end
    end else if (!wait_r) begin
      cmd.op   = op;
      wait_nxt = 1'b1;
    end else if (sts.done) begin
      wait_nxt  = 1'b0;
      state_nxt = adv;
      if (state_r == S_NEWD) n_nxt = n_r + 1'b1;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ hdl/icf_datapath.sv @@
// Datapath: operand registers and one shared bit-serial unit for multiply,
// divide and square root, plus the result register. Depends on icf_pkg.
module icf_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  icf_pkg::icf_cfg_t   cfg,
  input  icf_pkg::icf_in_t    in_data,
  input  icf_pkg::icf_cmd_t   cmd,
  output icf_pkg::icf_sts_t   sts,
  output icf_pkg::icf_out_t   out_data
);
  import icf_pkg::*;

  logic signed [WORD_BITS-1:0] x_r, y_r, z_r, r_r, half_r, c_r, d_r, sum_r, dx_r;
  logic signed [WORD_BITS-1:0] term_r, s_r, q_r, rr_r;
  logic signed [WORD_BITS-1:0] x_nxt, y_nxt, z_nxt, r_nxt, half_nxt, c_nxt, d_nxt;
  logic signed [WORD_BITS-1:0] sum_nxt, dx_nxt, term_nxt, s_nxt, q_nxt, rr_nxt;
  logic [PROD_BITS-1:0] sq_r, sq_nxt, wide_r, wide_nxt;
  logic [WORD_BITS-1:0] root_r, root_nxt, opnd_r, opnd_nxt, sroot_r, sroot_nxt;
  logic [REM_BITS-1:0]  rem_r, rem_nxt;
  logic neg_r, neg_nxt, dz_r, dz_nxt, conv_r, conv_nxt;
  icf_out_t out_r, out_nxt;

  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  icf_op_t op_r, op_nxt;

  logic signed [WORD_BITS-1:0] sel_a, sel_b, div_res, res;
  logic [WORD_BITS:0]   mul_sum, div_sh, div_rem;
  logic [PROD_BITS-1:0] mul_wide;
  logic                 div_ge, sq_ge, last, div_wr;
  logic [NUM_BITS-1:0]  div_quo;
  logic [REM_BITS-1:0]  sq_sh, sq_trial, sq_rem;
  logic [WORD_BITS-1:0] sq_root;
  icf_op_t              div_dst;

  // one step of each serial form
  assign mul_sum  = {1'b0, wide_r[PROD_BITS-1:WORD_BITS]}
                  + {1'b0, (wide_r[0] ? opnd_r : {WORD_BITS{1'b0}})};
  assign mul_wide = {mul_sum, wide_r[WORD_BITS-1:1]};
  assign div_sh   = {rem_r[WORD_BITS-1:0], wide_r[NUM_BITS-1]};
  assign div_ge   = div_sh >= {1'b0, opnd_r};
  assign div_rem  = div_ge ? div_sh - {1'b0, opnd_r} : div_sh;
  assign div_quo  = {wide_r[NUM_BITS-2:0], div_ge};
  assign sq_sh    = {rem_r[REM_BITS-3:0], wide_r[PROD_BITS-1:PROD_BITS-2]};
  assign sq_trial = {2'b00, sroot_r, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_rem   = sq_ge ? sq_sh - sq_trial : sq_sh;
  assign sq_root  = {sroot_r[WORD_BITS-2:0], sq_ge};
  assign last     = (cnt_r == CNT_BITS'(1));

  always_comb begin
    sel_a = c_r;
    sel_b = r_r;
    unique case (cmd.op)
      OP_SQX:    begin sel_a = dx_r;  sel_b = dx_r;  end
      OP_SQY:    begin sel_a = y_r;   sel_b = y_r;   end
      OP_SQZ:    begin sel_a = z_r;   sel_b = z_r;   end
      OP_TOL:    begin sel_a = $signed(WORD_BITS'(cfg.tolerance)); sel_b = sum_r; end
      OP_MULCQ:  begin sel_a = c_r;   sel_b = q_r;   end
      OP_MULRR:  begin sel_a = r_r;   sel_b = r_r;   end
      OP_TERM:   begin sel_a = c_r;   sel_b = $signed(root_r); end
      OP_DIVRS:  begin sel_a = r_r;   sel_b = s_r;   end
      OP_DIVRRS: begin sel_a = rr_r;  sel_b = s_r;   end
      default:   begin sel_a = c_r;   sel_b = r_r;   end
    endcase
  end

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; r_nxt = r_r; half_nxt = half_r;
    c_nxt = c_r; d_nxt = d_r; sum_nxt = sum_r; dx_nxt = dx_r; term_nxt = term_r;
    s_nxt = s_r; q_nxt = q_r; rr_nxt = rr_r; sq_nxt = sq_r; wide_nxt = wide_r;
    root_nxt = root_r; opnd_nxt = opnd_r; sroot_nxt = sroot_r; rem_nxt = rem_r;
    neg_nxt = neg_r; dz_nxt = dz_r; conv_nxt = conv_r; out_nxt = out_r;
    busy_nxt = busy_r; cnt_nxt = cnt_r; op_nxt = op_r; done_nxt = 1'b0;
    div_wr = 1'b0; div_dst = op_r; div_res = sat_mag(div_quo, neg_r);
    res = cmd.capped ? ONE_Q : sum_r;

    if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      unique case (op_r)
        OP_SQX, OP_SQY, OP_SQZ, OP_TOL, OP_MULCQ, OP_MULRR: begin
          wide_nxt = mul_wide;
          if (last) begin
            unique case (op_r)
              OP_TOL: begin
                conv_nxt = {mag(term_r), {TOL_BITS{1'b0}}}
                         < mul_wide[WORD_BITS+TOL_BITS-1:0];
                sum_nxt  = add_sat(sum_r, term_r);
              end
              OP_MULCQ: c_nxt  = sat_mag(mul_wide[PROD_BITS-1:FRAC_BITS], neg_r);
              OP_MULRR: rr_nxt = sat_mag(mul_wide[PROD_BITS-1:FRAC_BITS], neg_r);
              default:  sq_nxt = sq_r + mul_wide;
            endcase
          end
        end
        OP_TERM, OP_DIVRS, OP_DIVRRS: begin
          rem_nxt  = REM_BITS'(div_rem);
          wide_nxt = {wide_r[PROD_BITS-1:NUM_BITS], div_quo};
          if (last) div_wr = 1'b1;
        end
        default: begin
          rem_nxt   = sq_rem;
          sroot_nxt = sq_root;
          wide_nxt  = {wide_r[PROD_BITS-3:0], 2'b00};
          if (last) root_nxt = sq_root[WORD_BITS-1] ? WORD_BITS'(MAXV) : sq_root;
        end
      endcase
    end else if (cmd.op != OP_NONE) begin
      op_nxt  = cmd.op;
      neg_nxt = sel_a[WORD_BITS-1] ^ sel_b[WORD_BITS-1];
      unique case (cmd.op)
        OP_LOAD: begin
          x_nxt    = in_data.pos_x;
          y_nxt    = in_data.pos_y;
          z_nxt    = in_data.pos_z;
          r_nxt    = $signed(WORD_BITS'(cfg.hole_radius));
          half_nxt = cfg.hole_separation >>> 1;
          c_nxt    = $signed(WORD_BITS'(cfg.hole_radius));
          d_nxt    = cfg.hole_separation >>> 1;
          sum_nxt  = HALF_Q;
          dz_nxt   = 1'b0;
        end
        OP_DX: begin
          dx_nxt   = cfg.image_side ? add_sat(x_r, d_r) : sub_sat(x_r, d_r);
          sq_nxt   = '0;
          done_nxt = 1'b1;
        end
        OP_SQX, OP_SQY, OP_SQZ, OP_TOL, OP_MULCQ, OP_MULRR: begin
          opnd_nxt = mag(sel_a);
          wide_nxt = {{WORD_BITS{1'b0}}, mag(sel_b)};
          cnt_nxt  = CNT_BITS'(WORD_BITS);
          busy_nxt = 1'b1;
        end
        OP_TERM, OP_DIVRS, OP_DIVRRS: begin
          if (sel_b == '0) begin
            // zero divisor: saturate with the dividend's sign and flag
            dz_nxt   = 1'b1;
            div_wr   = 1'b1;
            div_dst  = cmd.op;
            div_res  = sel_a[WORD_BITS-1] ? MINV : MAXV;
            done_nxt = 1'b1;
          end else begin
            opnd_nxt = mag(sel_b);
            wide_nxt = PROD_BITS'({mag(sel_a), {FRAC_BITS{1'b0}}});
            rem_nxt  = '0;
            cnt_nxt  = CNT_BITS'(NUM_BITS);
            busy_nxt = 1'b1;
          end
        end
        OP_SQRT: begin
          wide_nxt  = sq_r;
          rem_nxt   = '0;
          sroot_nxt = '0;
          cnt_nxt   = CNT_BITS'(WORD_BITS);
          busy_nxt  = 1'b1;
        end
        OP_SUMS: begin
          s_nxt    = add_sat(half_r, d_r);
          done_nxt = 1'b1;
        end
        OP_NEWD: begin
          d_nxt    = sub_sat(half_r, q_r);
          done_nxt = 1'b1;
        end
        OP_OUT: begin
          out_nxt.psi_value = res[WORD_BITS-1] ? '0 : res[PSI_BITS-1:0];
          out_nxt.status    = dz_r ? ST_DZ : (cmd.capped ? ST_CAP : ST_CONV);
        end
        default: op_nxt = op_r;
      endcase
    end

    if (div_wr) begin
      if (div_dst == OP_TERM) term_nxt = div_res;
      else q_nxt = div_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_NONE;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; r_r <= r_nxt; half_r <= half_nxt;
    c_r <= c_nxt; d_r <= d_nxt; sum_r <= sum_nxt; dx_r <= dx_nxt; term_r <= term_nxt;
    s_r <= s_nxt; q_r <= q_nxt; rr_r <= rr_nxt; sq_r <= sq_nxt; wide_r <= wide_nxt;
    root_r <= root_nxt; opnd_r <= opnd_nxt; sroot_r <= sroot_nxt; rem_r <= rem_nxt;
    neg_r <= neg_nxt; dz_r <= dz_nxt; conv_r <= conv_nxt; out_r <= out_nxt;
  end

  assign sts.done = done_r;
  assign sts.conv = conv_r;
  assign out_data = out_r;

endmodule

@@ hdl/image_charge_conformal_factor.sv @@
// Top level of the image-charge conformal factor block: configuration
// registers, sequencer and datapath. Depends on icf_pkg, icf_ctrl, icf_datapath.
//
//   channel | handshake           | beat
//   in      | in_valid / in_stall | icf_in_t   (pos_x, pos_y, pos_z)
//   out     | out_valid/out_stall | icf_out_t  (psi_value, status)
//   cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One point runs T series terms (up to max_terms+1) from accept to the next
// accept, plus any wait for the output register.
// Each term runs three squares, a square root, a divide and a multiply;
// every term but the last adds the recurrence with two divides and two
// multiplies. All go through one bit-serial unit, one bit (two for the root)
// a cycle; the sequencer issues each step and waits for its done strobe.
// One point is in flight at a time; in_stall is low only when idle.
// A finished result sits in the output register and may be stalled while the
// next point is taken. Synchronous active-low reset loads the configuration defaults and clears the control state.
module image_charge_conformal_factor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  icf_pkg::icf_in_t    in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output icf_pkg::icf_out_t   out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [icf_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [icf_pkg::WORD_BITS-1:0]    cfg_data
);
  import icf_pkg::*;

  icf_cfg_t cfg_r, cfg_nxt;
  icf_cmd_t cmd;
  icf_sts_t sts;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RADIUS: cfg_nxt.hole_radius     = cfg_data[RAD_BITS-1:0];
        CFG_SEP:    cfg_nxt.hole_separation = $signed(cfg_data);
        CFG_TOL:    cfg_nxt.tolerance       = cfg_data[TOL_BITS-1:0];
        CFG_MAXT:   cfg_nxt.max_terms       = cfg_data[MT_BITS-1:0];
        CFG_SIDE:   cfg_nxt.image_side      = cfg_data[0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hole_radius     <= RAD_BITS'(ONE_Q);
      cfg_r.hole_separation <= ONE_Q <<< 3;
      cfg_r.tolerance       <= TOL_BITS'(109951);
      cfg_r.max_terms       <= MT_BITS'(30);
      cfg_r.image_side      <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  icf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .max_terms (cfg_r.max_terms),
    .sts       (sts),
    .cmd       (cmd)
  );

  icf_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
